// ===== rtl/core/rtp_pkg.sv =====
package rtp_pkg;

   localparam int TICK_MS = 10;
   localparam int MS_PER_SEC = 1000;
   localparam int SEC_PER_MIN = 60;
   localparam int BEATS_PER_WHOLE = 4;
   localparam int MS_PER_MIN = MS_PER_SEC * SEC_PER_MIN;

   localparam int TICK_SHIFT = 25;
   localparam int TICK_RECIP = (2 ** TICK_SHIFT + TICK_MS - 1) / TICK_MS;
   localparam int RECIP_W = $clog2(TICK_RECIP + 1);

   localparam int DIV_W = 18;
   localparam int DIVISOR_W = 10;
   localparam int DIV_CNT_W = $clog2(DIV_W + 1);

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

   localparam int NOTES_PER_OCT = 12;
   localparam int OCT_LO = 2;
   localparam int OCT_HI = 7;
   localparam int IDX_MAX = 72;
   localparam int LEN_SAT = 255;
   localparam int DEF_LEN_FALLBACK = 4;

   localparam logic [1:0] CSR_TEMPO = 2'd0;
   localparam logic [1:0] CSR_DEF_LEN = 2'd1;
   localparam logic [1:0] CSR_DEF_OCT = 2'd2;

   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_SHARP = 8'h23;
   localparam logic [7:0] CH_DOT = 8'h2e;
   localparam logic [7:0] CH_COMMA = 8'h2c;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [6:0]  note_index;
      logic [15:0] duration_ticks;
      logic        range_error;
      logic        last_note;
   } rsp_type;

   typedef struct packed {
      logic [9:0] tempo_bpm;
      logic [5:0] default_length;
      logic [2:0] default_octave;
   } cfg_type;

   typedef struct packed {
      logic [7:0] length_digits;
      logic [3:0] semitone;
      logic       dotted;
      logic [3:0] octave;
      logic       last;
   } note_cmd_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] semitone;
   } letter_type;

   function automatic letter_type letter_lookup(input logic [7:0] c);
      letter_type r;
      r.hit = 1'b1;
      unique case (c) inside
         8'h43, 8'h63: r.semitone = 4'd1;
         8'h44, 8'h64: r.semitone = 4'd3;
         8'h45, 8'h65: r.semitone = 4'd5;
         8'h46, 8'h66: r.semitone = 4'd6;
         8'h47, 8'h67: r.semitone = 4'd8;
         8'h41, 8'h61: r.semitone = 4'd10;
         8'h42, 8'h62: r.semitone = 4'd12;
         8'h50, 8'h70: r.semitone = 4'd0;
         default: begin
            r.hit = 1'b0;
            r.semitone = 4'd0;
         end
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/core/rtp_front.sv =====
module rtp_front
   import rtp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_type      req_data,
   output logic         push_valid,
   input  logic         push_ready,
   output note_cmd_type push_data
);

   typedef enum logic [1:0] {PH_DUR, PH_LETTER, PH_SHARP, PH_OCT} phase_type;

   phase_type    phase_ff, phase_in;
   logic [7:0]   len_ff, len_in;
   logic [3:0]   semi_ff, semi_in;
   logic         dot_ff, dot_in;
   logic [3:0]   oct_ff, oct_in;
   logic         pend_ff, pend_in;
   note_cmd_type cmd0_ff, cmd0_in, cmd1_ff, cmd1_in;
   logic         cmd0_v_ff, cmd0_v_in, cmd1_v_ff, cmd1_v_in;

   logic         accept;
   logic         is_digit;
   logic [3:0]   digit;
   logic [11:0]  len_acc;
   letter_type   letter;
   logic [7:0]   c;
   logic         emit_a;
   logic         emit_b;
   logic [3:0]   def_oct;

   assign req_ready = !cmd0_v_ff && !cmd1_v_ff;
   assign accept = req_valid && req_ready;
   assign c = req_data.char_code;
   assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
   assign digit = 4'(c - CH_ZERO);
   assign len_acc = {1'b0, len_ff, 3'b000} + {3'b000, len_ff, 1'b0} + {8'd0, digit};
   assign letter = letter_lookup(c);
   assign def_oct = {1'b0, cfg.default_octave};

   assign push_valid = cmd0_v_ff || cmd1_v_ff;
   assign push_data = cmd0_v_ff ? cmd0_ff : cmd1_ff;

   always_comb begin
      phase_in = phase_ff;
      len_in = len_ff;
      semi_in = semi_ff;
      dot_in = dot_ff;
      oct_in = oct_ff;
      pend_in = pend_ff;
      emit_a = 1'b0;
      emit_b = 1'b0;
      cmd0_in.length_digits = len_ff;
      cmd0_in.semitone = semi_ff;
      cmd0_in.dotted = dot_ff;
      cmd0_in.octave = oct_ff;
      cmd0_in.last = 1'b0;
      if (accept) begin
         if (is_digit) begin
            if (phase_ff == PH_DUR) begin
               len_in = (len_acc > 12'(LEN_SAT)) ? 8'(LEN_SAT) : len_acc[7:0];
               pend_in = 1'b1;
            end else if (phase_ff == PH_OCT) begin
               emit_a = 1'b1;
               phase_in = PH_DUR;
               len_in = {4'd0, digit};
               semi_in = 4'd0;
               dot_in = 1'b0;
               oct_in = def_oct;
               pend_in = 1'b1;
            end else begin
               oct_in = digit;
               phase_in = PH_OCT;
            end
         end else if (letter.hit) begin
            if (phase_ff != PH_DUR) begin
               emit_a = 1'b1;
               len_in = 8'd0;
               dot_in = 1'b0;
               oct_in = def_oct;
            end
            semi_in = letter.semitone;
            phase_in = PH_LETTER;
            pend_in = 1'b1;
         end else if (c == CH_SHARP) begin
            if (phase_ff == PH_LETTER && semi_ff != 4'd0) begin
               semi_in = semi_ff + 4'd1;
               phase_in = PH_SHARP;
            end
         end else if (c == CH_DOT) begin
            if (phase_ff != PH_DUR && !dot_ff) begin
               dot_in = 1'b1;
               if (phase_ff == PH_LETTER) begin
                  phase_in = PH_SHARP;
               end
            end
         end else if (c == CH_COMMA) begin
            if (pend_ff) begin
               emit_a = 1'b1;
               phase_in = PH_DUR;
               len_in = 8'd0;
               semi_in = 4'd0;
               dot_in = 1'b0;
               oct_in = def_oct;
               pend_in = 1'b0;
            end
         end
      end
      cmd1_in.length_digits = len_in;
      cmd1_in.semitone = semi_in;
      cmd1_in.dotted = dot_in;
      cmd1_in.octave = oct_in;
      cmd1_in.last = 1'b1;
      if (accept && req_data.end_of_text) begin
         emit_b = pend_in;
         cmd0_in.last = !pend_in;
         phase_in = PH_DUR;
         len_in = 8'd0;
         semi_in = 4'd0;
         dot_in = 1'b0;
         oct_in = def_oct;
         pend_in = 1'b0;
      end
      cmd0_v_in = cmd0_v_ff;
      cmd1_v_in = cmd1_v_ff;
      if (push_valid && push_ready) begin
         if (cmd0_v_ff) begin
            cmd0_v_in = 1'b0;
         end else begin
            cmd1_v_in = 1'b0;
         end
      end
      if (accept) begin
         cmd0_v_in = emit_a;
         cmd1_v_in = emit_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DUR;
         len_ff <= 8'd0;
         semi_ff <= 4'd0;
         dot_ff <= 1'b0;
         oct_ff <= 4'(OCT_LO + 2);
         pend_ff <= 1'b0;
         cmd0_v_ff <= 1'b0;
         cmd1_v_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         len_ff <= len_in;
         semi_ff <= semi_in;
         dot_ff <= dot_in;
         oct_ff <= oct_in;
         pend_ff <= pend_in;
         cmd0_v_ff <= cmd0_v_in;
         cmd1_v_ff <= cmd1_v_in;
      end
      if (accept) begin
         cmd0_ff <= cmd0_in;
         cmd1_ff <= cmd1_in;
      end
   end

endmodule

// ===== rtl/core/rtp_queue.sv =====
module rtp_queue
   import rtp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  note_cmd_type push_data,
   output logic         pop_valid,
   input  logic         pop,
   output note_cmd_type pop_data
);

   note_cmd_type             mem_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]        count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign push_ready = count_ff != (QUEUE_AW + 1)'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== rtl/core/rtp_divider.sv =====
module rtp_divider
   import rtp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_W-1:0]     dividend,
   input  logic [DIVISOR_W-1:0] divisor,
   output logic                 done,
   output logic [DIV_W-1:0]     quotient
);

   logic [DIV_W-1:0]     quo_ff, quo_in;
   logic [DIVISOR_W-1:0] rem_ff, rem_in;
   logic [DIVISOR_W-1:0] dsr_ff;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIVISOR_W:0]   rem_shift;
   logic                 ge;

   assign rem_shift = {rem_ff, quo_ff[DIV_W-1]};
   assign ge = rem_shift >= {1'b0, dsr_ff};
   assign done = done_ff;
   assign quotient = quo_ff;

   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         cnt_in = DIV_CNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? DIVISOR_W'(rem_shift - {1'b0, dsr_ff}) : rem_shift[DIVISOR_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (start) begin
         dsr_ff <= divisor;
      end
   end

endmodule

// ===== rtl/core/rtp_back.sv =====
module rtp_back
   import rtp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  logic         cmd_valid,
   output logic         cmd_pop,
   input  note_cmd_type cmd_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_type      rsp_data
);

   typedef enum logic [1:0] {B_IDLE, B_BEAT, B_LEN, B_OUT} state_type;

   state_type            state_ff;
   note_cmd_type         cmd_ff;
   logic                 start_ff;
   logic [DIV_W-1:0]     dividend_ff;
   logic [DIVISOR_W-1:0] divisor_ff;
   rsp_type              rsp_ff;
   logic [6:0]           idx_ff;
   logic                 err_ff;

   logic                 div_done;
   logic [DIV_W-1:0]     quo;
   logic [DIVISOR_W-1:0] bpm;
   logic [DIVISOR_W-1:0] len_div;
   logic [7:0]           raw;
   logic [6:0]           idx;
   logic                 err;
   logic [DIV_W:0]       dur_sum;
   logic [15:0]          dur;
   logic [DIV_W-1:0]         beats_whole;
   logic [DIV_W+RECIP_W-1:0] whole_prod;
   logic [DIV_W-1:0]         whole;

   rtp_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (start_ff),
      .dividend (dividend_ff),
      .divisor  (divisor_ff),
      .done     (div_done),
      .quotient (quo)
   );

   assign cmd_pop = (state_ff == B_IDLE) && cmd_valid;
   assign rsp_valid = state_ff == B_OUT;
   assign rsp_data = rsp_ff;

   assign bpm = (cfg.tempo_bpm == '0) ? DIVISOR_W'(1) : cfg.tempo_bpm;

   assign beats_whole = DIV_W'(quo * BEATS_PER_WHOLE);
   assign whole_prod = beats_whole * RECIP_W'(TICK_RECIP);
   assign whole = DIV_W'(whole_prod >> TICK_SHIFT);

   always_comb begin
      if (cmd_ff.length_digits != 8'd0) begin
         len_div = DIVISOR_W'(cmd_ff.length_digits);
      end else if (cfg.default_length != 6'd0) begin
         len_div = DIVISOR_W'(cfg.default_length);
      end else begin
         len_div = DIVISOR_W'(DEF_LEN_FALLBACK);
      end
   end

   always_comb begin
      raw = {1'b0, cmd_data.octave, 3'b000} + {2'b00, cmd_data.octave, 2'b00}
            + {4'd0, cmd_data.semitone};
      err = (cmd_data.octave < 4'(OCT_LO)) || (cmd_data.octave > 4'(OCT_HI));
      if (raw < 8'(OCT_LO * NOTES_PER_OCT + 1)) begin
         idx = 7'd1;
         err = 1'b1;
      end else if (raw > 8'(OCT_LO * NOTES_PER_OCT + IDX_MAX)) begin
         idx = 7'(IDX_MAX);
         err = 1'b1;
      end else begin
         idx = 7'(raw - 8'(OCT_LO * NOTES_PER_OCT));
      end
      if (cmd_data.semitone == 4'd0) begin
         idx = 7'd0;
         err = 1'b0;
      end
   end

   always_comb begin
      dur_sum = {1'b0, quo} + (cmd_ff.dotted ? {2'b00, quo[DIV_W-1:1]} : '0);
      dur = (dur_sum > (DIV_W + 1)'(16'hffff)) ? 16'hffff : dur_sum[15:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         start_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (cmd_valid) begin
                  cmd_ff <= cmd_data;
                  idx_ff <= idx;
                  err_ff <= err;
                  start_ff <= 1'b1;
                  dividend_ff <= DIV_W'(MS_PER_MIN);
                  divisor_ff <= bpm;
                  state_ff <= B_BEAT;
               end
            end
            B_BEAT: begin
               if (div_done) begin
                  start_ff <= 1'b1;
                  dividend_ff <= whole;
                  divisor_ff <= len_div;
                  state_ff <= B_LEN;
               end
            end
            B_LEN: begin
               if (div_done) begin
                  rsp_ff.note_index <= idx_ff;
                  rsp_ff.duration_ticks <= dur;
                  rsp_ff.range_error <= err_ff;
                  rsp_ff.last_note <= cmd_ff.last;
                  state_ff <= B_OUT;
               end
            end
            B_OUT: begin
               if (rsp_ready) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/core/ringtone_note_parser.sv =====
// Ringtone note parser: melody body characters in, one note per closed note out.
// Input channel req_*: one character and an end-of-text flag per beat. The
// parser takes a character each cycle while it holds no closed note that is
// still waiting for the note queue; a character that closes two notes (end of
// text after a started note) stalls input until the queue has taken both.
// Result channel rsp_*: one beat per note with index, length in ticks, range
// flag and last-note flag, in melody order.
// One shared 18-step restoring divider runs two passes per note (minute by
// tempo, whole note by length), and a reciprocal multiply turns the beat
// length into whole-note ticks between them. The note timing works on one
// note at a time: it takes the next note from the queue only after the
// receiver has taken the result of the last one.
// A four-entry note queue sits between parser and note timing; when the
// receiver stalls, the result register holds, the queue fills, and then the
// parser stops taking characters.
// Reset (synchronous, active high) clears the parse state, empties the queue
// and loads tempo 120, default length 4, default octave 4.
// csr_*: write-only registers; write only while idle (the user's duty: not enforced).
module ringtone_note_parser
   import rtp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [9:0] csr_wdata,
   input  logic       req_valid,
   output logic       req_ready,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output rsp_type    rsp_data
);

   cfg_type      cfg_ff;
   logic         push_valid;
   logic         push_ready;
   note_cmd_type push_data;
   logic         pop_valid;
   logic         pop;
   note_cmd_type pop_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tempo_bpm <= 10'd120;
         cfg_ff.default_length <= 6'd4;
         cfg_ff.default_octave <= 3'd4;
      end else if (csr_we) begin
         case (csr_index)
            CSR_TEMPO: cfg_ff.tempo_bpm <= csr_wdata;
            CSR_DEF_LEN: cfg_ff.default_length <= csr_wdata[5:0];
            CSR_DEF_OCT: cfg_ff.default_octave <= csr_wdata[2:0];
            default: cfg_ff <= cfg_ff;
         endcase
      end
   end

   rtp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   rtp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   rtp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (pop_valid),
      .cmd_pop   (pop),
      .cmd_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== sim/tb_ringtone_note_parser.sv =====
`timescale 1ns / 100ps

module tb_ringtone_note_parser;
   import rtp_pkg::*;

   localparam int unsigned STALL_LIMIT = 5000;
   localparam int unsigned SETTLE_CYCLES = 200;
   localparam int unsigned ITEMS_PER_PHASE = 191;
   localparam int unsigned PHASES = 8;

   typedef enum logic [1:0] {
      PH_DUR,
      PH_LETTER,
      PH_SHARP,
      PH_OCT
   } parse_phase_e;

   class note_tracker;
      logic [9:0] tempo_bpm;
      logic [5:0] def_len;
      logic [2:0] def_oct;
      parse_phase_e phase;
      int unsigned digits;
      logic [3:0] semi;
      bit dotted;
      logic [3:0] octave;
      bit pending;
      rsp_type notes_due[$];
      int errors;

      function void restart();
         phase = PH_DUR;
         digits = 0;
         semi = 4'd0;
         dotted = 1'b0;
         octave = {1'b0, def_oct};
         pending = 1'b0;
      endfunction

      function void reset_all();
         tempo_bpm = 10'd120;
         def_len = 6'd4;
         def_oct = 3'd4;
         errors = 0;
         restart();
      endfunction

      function void set_config(logic [9:0] bpm, logic [5:0] len, logic [2:0] oct);
         tempo_bpm = bpm;
         def_len = len;
         def_oct = oct;
      endfunction

      function bit letter_code(input logic [7:0] c, output logic [3:0] s);
         bit hit;
         hit = 1'b1;
         s = 4'd0;
         case (c)
            "C", "c": s = 4'd1;
            "D", "d": s = 4'd3;
            "E", "e": s = 4'd5;
            "F", "f": s = 4'd6;
            "G", "g": s = 4'd8;
            "A", "a": s = 4'd10;
            "B", "b": s = 4'd12;
            "P", "p": s = 4'd0;
            default: hit = 1'b0;
         endcase
         return hit;
      endfunction

      function rsp_type close_note(bit last);
         rsp_type n;
         int unsigned bpm;
         int unsigned whole;
         int unsigned divisor;
         int unsigned ticks;
         int v;
         bpm = (tempo_bpm != 0) ? tempo_bpm : 1;
         whole = ((MS_PER_MIN / bpm) * BEATS_PER_WHOLE) / TICK_MS;
         if (digits != 0) begin
            divisor = digits;
         end else begin
            divisor = (def_len != 0) ? def_len : DEF_LEN_FALLBACK;
         end
         ticks = whole / divisor;
         if (dotted) begin
            ticks = ticks + ticks / 2;
         end
         if (ticks > 65535) begin
            ticks = 65535;
         end
         n.note_index = 7'd0;
         n.range_error = 1'b0;
         if (semi != 0) begin
            v = (int'(octave) - OCT_LO) * NOTES_PER_OCT + int'(semi);
            if (int'(octave) < OCT_LO || int'(octave) > OCT_HI) begin
               n.range_error = 1'b1;
            end
            if (v < 1) begin
               v = 1;
               n.range_error = 1'b1;
            end else if (v > IDX_MAX) begin
               v = IDX_MAX;
               n.range_error = 1'b1;
            end
            n.note_index = v[6:0];
         end
         n.duration_ticks = ticks[15:0];
         n.last_note = last;
         restart();
         return n;
      endfunction

      function void take_char(req_type r);
         rsp_type made[2];
         int n;
         logic [7:0] c;
         logic [3:0] s;
         bit letter;
         n = 0;
         c = r.char_code;
         letter = letter_code(c, s);
         if (c >= CH_ZERO && c <= CH_NINE) begin
            if (phase == PH_DUR) begin
               digits = digits * 10 + (c - CH_ZERO);
               if (digits > LEN_SAT) begin
                  digits = LEN_SAT;
               end
               pending = 1'b1;
            end else if (phase == PH_OCT) begin
               made[n] = close_note(1'b0);
               n++;
               digits = c - CH_ZERO;
               pending = 1'b1;
            end else begin
               octave = 4'(c - CH_ZERO);
               phase = PH_OCT;
            end
         end else if (letter) begin
            if (phase != PH_DUR) begin
               made[n] = close_note(1'b0);
               n++;
            end
            semi = s;
            phase = PH_LETTER;
            pending = 1'b1;
         end else if (c == CH_SHARP) begin
            if (phase == PH_LETTER && semi != 0) begin
               semi = semi + 4'd1;
               phase = PH_SHARP;
            end
         end else if (c == CH_DOT) begin
            if (phase != PH_DUR && !dotted) begin
               dotted = 1'b1;
               if (phase == PH_LETTER) begin
                  phase = PH_SHARP;
               end
            end
         end else if (c == CH_COMMA && pending) begin
            made[n] = close_note(1'b0);
            n++;
         end
         if (r.end_of_text) begin
            if (pending) begin
               made[n] = close_note(1'b1);
               n++;
            end else if (n > 0) begin
               made[n-1].last_note = 1'b1;
            end
            restart();
         end
         for (int i = 0; i < n; i++) begin
            notes_due.push_back(made[i]);
         end
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) begin
            $display("mismatch at %0t: %s", $realtime, msg);
         end
      endtask

      task check_note(rsp_type got);
         rsp_type want;
         if (notes_due.size() == 0) begin
            report($sformatf("note with none due: index %0d ticks %0d",
                             got.note_index, got.duration_ticks));
            return;
         end
         want = notes_due.pop_front();
         if (got.note_index !== want.note_index) begin
            report($sformatf("note_index %0d, want %0d", got.note_index, want.note_index));
         end
         if (got.duration_ticks !== want.duration_ticks) begin
            report($sformatf("duration_ticks %0d, want %0d",
                             got.duration_ticks, want.duration_ticks));
         end
         if (got.range_error !== want.range_error) begin
            report($sformatf("range_error %b, want %b", got.range_error, want.range_error));
         end
         if (got.last_note !== want.last_note) begin
            report($sformatf("last_note %b, want %b", got.last_note, want.last_note));
         end
      endtask
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = CSR_TEMPO;
   logic [9:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;

   note_tracker notes;
   bit steady = 1'b0;
   int unsigned quiet_cycles = 0;
   int unsigned chars_sent = 0;

   ringtone_note_parser dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            notes.check_note(rsp_data);
         end
         rsp_ready <= steady || ($urandom_range(99) >= 36);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   task automatic send_beat(input req_type r);
      while (!steady && $urandom_range(99) < 36) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      notes.take_char(r);
      chars_sent++;
   endtask

   task automatic send_text(input string s, input bit eot_at_end);
      req_type r;
      for (int i = 0; i < s.len(); i++) begin
         r.char_code = s[i];
         r.end_of_text = eot_at_end && (i == s.len() - 1);
         send_beat(r);
      end
   endtask

   task automatic send_byte(input logic [7:0] c);
      req_type r;
      r.char_code = c;
      r.end_of_text = 1'b0;
      send_beat(r);
   endtask

   task automatic send_random_note();
      logic [7:0] text[$];
      string letters = "cdefgabpCDEFGABP";
      string stray = ".#, 0";
      int unsigned oct;
      bit eot;
      req_type r;
      if ($urandom_range(9) == 0) begin
         repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(1) == 0) begin
               text.push_back(8'($urandom_range(255)));
            end else begin
               text.push_back(stray[$urandom_range(4)]);
            end
         end
      end else begin
         repeat ($urandom_range(3)) text.push_back(CH_ZERO + 8'($urandom_range(9)));
         text.push_back(letters[$urandom_range(15)]);
         if ($urandom_range(2) == 0) begin
            text.push_back(CH_SHARP);
         end
         if ($urandom_range(4) == 0) begin
            text.push_back(CH_DOT);
         end
         if ($urandom_range(9) < 6) begin
            oct = ($urandom_range(9) < 8) ? $urandom_range(OCT_LO, OCT_HI) : $urandom_range(9);
            text.push_back(CH_ZERO + 8'(oct));
         end
         if ($urandom_range(9) == 0) begin
            text.push_back(CH_DOT);
         end
         if ($urandom_range(9) < 7) begin
            text.push_back(CH_COMMA);
         end
      end
      eot = ($urandom_range(24) == 0);
      foreach (text[i]) begin
         r.char_code = text[i];
         r.end_of_text = eot ? (i == text.size() - 1) : ($urandom_range(199) == 0);
         send_beat(r);
      end
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (notes.notes_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_config(input logic [9:0] bpm, input logic [5:0] len,
                               input logic [2:0] oct);
      csr_we <= 1'b1;
      csr_index <= CSR_TEMPO;
      csr_wdata <= bpm;
      @(posedge clock);
      csr_index <= CSR_DEF_LEN;
      csr_wdata <= 10'(len);
      @(posedge clock);
      csr_index <= CSR_DEF_OCT;
      csr_wdata <= 10'(oct);
      @(posedge clock);
      csr_we <= 1'b0;
      notes.set_config(bpm, len, oct);
   endtask

   initial begin
      notes = new();
      notes.reset_all();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_text(",.999c#.9.5P#A.#", 1'b0);
      send_byte(8'hff);
      send_byte(8'h00);
      send_text("b1,0,", 1'b0);
      send_text("g", 1'b1);
      send_text("e,", 1'b1);
      send_text(" ", 1'b1);

      for (int p = 1; p <= PHASES; p++) begin
         settle();
         case (p)
            1: write_config(10'd999, 6'd32, 3'd7);
            2: write_config(10'd1, 6'd1, 3'd2);
            3: write_config(10'd0, 6'd0, 3'($urandom_range(7)));
            4: write_config(10'($urandom_range(1, 999)), 6'($urandom_range(1, 32)),
                            3'($urandom_range(OCT_LO, OCT_HI)));
            default: write_config(10'($urandom_range(1023)), 6'($urandom_range(63)),
                                  3'($urandom_range(7)));
         endcase
         steady = (p == 4);
         while (chars_sent < 26 + p * ITEMS_PER_PHASE) begin
            send_random_note();
         end
         steady = 1'b0;
      end

      settle();
      if (notes.notes_due.size() != 0) begin
         notes.report("notes never delivered");
      end
      if (notes.errors == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== ringtone_note_parser.f =====
rtl/core/rtp_pkg.sv
rtl/core/rtp_front.sv
rtl/core/rtp_queue.sv
rtl/core/rtp_divider.sv
rtl/core/rtp_back.sv
rtl/core/ringtone_note_parser.sv
sim/tb_ringtone_note_parser.sv
